// ----- hw/rtl/gcg_pkg.sv -----
// Shared types, codes and constants of the gradient colour generator.
`default_nettype none
package gcg_pkg;

   localparam int TABLE_DEPTH = 512;
   localparam int TABLE_AW = $clog2(TABLE_DEPTH);
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int SPAN_W = 12;
   localparam int ACC_W = 128;
   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd40;
   localparam logic [CNT_W-1:0] DIV_STEPS = 7'd80;
   localparam logic signed [16:0] FOCAL_LIMIT = 17'sd64880;

   localparam logic [2:0] MODE_LIN_REPEAT = 3'd1;
   localparam logic [2:0] MODE_LIN_REFLECT = 3'd2;
   localparam logic [2:0] MODE_RAD_PAD = 3'd3;
   localparam logic [2:0] MODE_RAD_REPEAT = 3'd4;
   localparam logic [2:0] MODE_RAD_REFLECT = 3'd5;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_SPAN   = 2'd1,
      REQ_PIXEL  = 2'd2,
      REQ_IGNORE = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_FILL_MODE   = 3'd0,
      CSR_FOCAL_RATIO = 3'd1,
      CSR_MATRIX_XX   = 3'd2,
      CSR_MATRIX_XY   = 3'd3,
      CSR_MATRIX_YX   = 3'd4,
      CSR_MATRIX_YY   = 3'd5,
      CSR_OFFSET_X    = 3'd6,
      CSR_OFFSET_Y    = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_SQRT = 2'd1,
      ALU_DIV  = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SX_A,
      ST_SX_B,
      ST_SY_A,
      ST_SY_B,
      ST_F2,
      ST_Y2,
      ST_X2,
      ST_D,
      ST_SQRT,
      ST_NUM,
      ST_DIV,
      ST_OUT
   } state_type;

   function automatic logic [ACC_W-1:0] sext40(input logic [39:0] v);
      return {{(ACC_W-40){v[39]}}, v};
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gcg_alu.sv -----
// Shared shift-add multiplier, bit-pair square root and restoring divider.
`default_nettype none
module gcg_alu (
   input  wire                            clock,
   input  wire                            reset,
   input  wire gcg_pkg::alu_cmd_type      cmd,
   input  wire [gcg_pkg::ACC_W-1:0]       x_init,
   input  wire [gcg_pkg::ACC_W-1:0]       y_init,
   input  wire [63:0]                     z_init,
   input  wire [32:0]                     divisor,
   output logic                           done,
   output logic [gcg_pkg::ACC_W-1:0]      x_out,
   output logic [63:0]                    z_out
);
   logic                          busy_ff, busy_in, done_ff, done_in;
   gcg_pkg::alu_op_type           op_ff, op_in;
   logic [gcg_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [gcg_pkg::ACC_W-1:0]     x_ff, x_in, y_ff, y_in;
   logic [63:0]                   z_ff, z_in;
   logic [32:0]                   dv_ff, dv_in;
   logic [gcg_pkg::ACC_W-1:0]     opa, opb;
   logic                          sub;
   logic [gcg_pkg::ACC_W:0]       sum;
   logic                          carry;

   // One adder serves every operation: add for multiply, subtract-and-test otherwise.
   always_comb begin
      opa = x_ff;
      opb = y_ff;
      sub = 1'b0;
      unique case (op_ff)
         gcg_pkg::ALU_MUL: begin
            opa = x_ff;
            opb = y_ff;
            sub = 1'b0;
         end
         gcg_pkg::ALU_SQRT: begin
            opa = {x_ff[gcg_pkg::ACC_W-3:0], y_ff[79:78]};
            opb = {62'b0, z_ff, 2'b01};
            sub = 1'b1;
         end
         gcg_pkg::ALU_DIV: begin
            opa = {x_ff[gcg_pkg::ACC_W-2:0], y_ff[79]};
            opb = {95'b0, dv_ff};
            sub = 1'b1;
         end
         default: begin
            opa = x_ff;
            opb = y_ff;
            sub = 1'b0;
         end
      endcase
      sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{gcg_pkg::ACC_W{1'b0}}, sub};
      carry = sum[gcg_pkg::ACC_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      dv_in = dv_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in = cmd.op;
         cnt_in = (cmd.op == gcg_pkg::ALU_SQRT) ? gcg_pkg::SQRT_STEPS : gcg_pkg::DIV_STEPS;
         x_in = x_init;
         y_in = y_init;
         z_in = z_init;
         dv_in = divisor;
      end else if (busy_ff) begin
         unique case (op_ff)
            gcg_pkg::ALU_MUL: begin
               if (z_ff == 64'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (z_ff[0]) begin
                     x_in = sum[gcg_pkg::ACC_W-1:0];
                  end
                  y_in = {y_ff[gcg_pkg::ACC_W-2:0], 1'b0};
                  z_in = {1'b0, z_ff[63:1]};
               end
            end
            gcg_pkg::ALU_SQRT: begin
               x_in = carry ? sum[gcg_pkg::ACC_W-1:0] : opa;
               z_in = {z_ff[62:0], carry};
               y_in = {y_ff[gcg_pkg::ACC_W-3:0], 2'b00};
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == 7'd1) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            gcg_pkg::ALU_DIV: begin
               x_in = carry ? sum[gcg_pkg::ACC_W-1:0] : opa;
               z_in = {z_ff[62:0], carry};
               y_in = {y_ff[gcg_pkg::ACC_W-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == 7'd1) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff <= gcg_pkg::ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff <= op_in;
      end
      cnt_ff <= cnt_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      dv_ff <= dv_in;
   end

   assign done = done_ff;
   assign x_out = x_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/gcg_ramp.sv -----
// Colour ramp memory with one write port and one registered read port.
`default_nettype none
module gcg_ramp (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire [gcg_pkg::TABLE_AW-1:0]     wr_addr,
   input  wire [31:0]                      wr_data,
   input  wire                             rd_en,
   input  wire [gcg_pkg::TABLE_AW-1:0]     rd_addr,
   output logic [31:0]                     rd_data
);
   logic [31:0] mem [gcg_pkg::TABLE_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/gradient_colour_generator_unit.sv -----
// Top level of the gradient colour generator: registers, sequencer and result register.
// Usage:
//   req_* carries one item per beat: a ramp load, a span start or a pixel request.
//   rsp_* returns one ARGB colour for each pixel request, in order; loads and
//   span starts return nothing. csr_* writes the mode, focal ratio and mapper
//   registers and is always ready; write it only while the block is idle.
// Sequence:
//   A load writes the ramp on acceptance and leaves the block idle. A linear
//   pixel reads the ramp into its registered read port; the result stage then
//   moves the colour to the output register, and no new item is taken until
//   it has. A span start runs two (linear) or four (radial) shift-add
//   multiplies. A radial pixel runs through the shared arithmetic unit: squares
//   and products, a 40-step square root (skipped when the root saturates) and
//   an 80-step division, all on the one shared adder of the arithmetic unit.
// Reset: registers go to their defaults (identity matrix, linear pad) and the
//   positions to zero; ramp entries are undefined until loaded.
// Stall: a finished colour waits in the output register; the block still takes
//   the next item, but a following pixel holds until that beat has gone.
`default_nettype none
module gradient_colour_generator_unit #(
   parameter int COORD_BITS = gcg_pkg::COORD_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // table_index [8:0], table_colour [40:9], span_x [52:41], span_y [64:53]
   input  wire [71:0]  req_tdata,
   // req_type [1:0]
   input  wire [1:0]   req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // pixel_colour [31:0]
   output logic [31:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [2:0]   csr_index,
   input  wire [39:0]  csr_data
);
   localparam int CB = (COORD_BITS < gcg_pkg::SPAN_W) ? COORD_BITS : gcg_pkg::SPAN_W;
   localparam logic [gcg_pkg::SPAN_W-1:0] CMASK = gcg_pkg::SPAN_W'((1 << CB) - 1);
   localparam int AW = gcg_pkg::ACC_W;

   gcg_pkg::state_type        state_ff, state_in;
   logic [2:0]                mode_ff;
   logic [16:0]               focal_ff;
   logic [39:0]               mxx_ff, mxy_ff, myx_ff, myy_ff, ox_ff, oy_ff;
   logic [31:0]               pos_ff, pos_in;
   logic [39:0]               gx_ff, gx_in, gy_ff, gy_in;
   logic [AW-1:0]             w_ff, w_in;
   logic [32:0]               g_ff, g_in;
   logic [12:0]               cx_ff, cx_in, cy_ff, cy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_data_ff, rsp_data_in;

   gcg_pkg::alu_cmd_type      alu_cmd;
   logic [AW-1:0]             alu_x, alu_y, alu_xo;
   logic [63:0]               alu_z, alu_zo;
   logic                      alu_done;

   logic                      rd_en, wr_en;
   logic [gcg_pkg::TABLE_AW-1:0] rd_addr;
   logic [31:0]               rd_data;

   logic                      radial, pad, wide;
   logic [8:0]                mask9;
   logic signed [16:0]        f_val;
   logic                      f_neg;
   logic [15:0]               f_abs;
   logic [39:0]               gx_abs, gy_abs;
   logic [40:0]               step_pad_sum, step_rep_sum;
   logic [31:0]               step;
   logic [8:0]                lin_idx;
   logic [63:0]               sx_pad, sx_rep;
   logic [AW-1:0]             sx_rnd, sy_rnd;
   logic [39:0]               s_val;
   logic [32:0]               a33;
   logic [41:0]               a_scaled;
   logic [8:0]                rad_idx;
   logic [12:0]               span_cx, span_cy;

   // Mode decode, focal clamp and absolute values of the gradient position.
   always_comb begin
      radial = (mode_ff == gcg_pkg::MODE_RAD_PAD) || (mode_ff == gcg_pkg::MODE_RAD_REPEAT) ||
               (mode_ff == gcg_pkg::MODE_RAD_REFLECT);
      pad = !((mode_ff == gcg_pkg::MODE_LIN_REPEAT) || (mode_ff == gcg_pkg::MODE_LIN_REFLECT) ||
              (mode_ff == gcg_pkg::MODE_RAD_REPEAT) || (mode_ff == gcg_pkg::MODE_RAD_REFLECT));
      wide = (mode_ff == gcg_pkg::MODE_LIN_REFLECT) || (mode_ff == gcg_pkg::MODE_RAD_REFLECT);
      mask9 = wide ? 9'h1FF : 9'h0FF;
      if ($signed(focal_ff) > gcg_pkg::FOCAL_LIMIT) begin
         f_val = gcg_pkg::FOCAL_LIMIT;
      end else if ($signed(focal_ff) < -gcg_pkg::FOCAL_LIMIT) begin
         f_val = -gcg_pkg::FOCAL_LIMIT;
      end else begin
         f_val = $signed(focal_ff);
      end
      f_neg = f_val[16];
      f_abs = f_neg ? 16'(-f_val) : f_val[15:0];
      gx_abs = gx_ff[39] ? (40'd0 - gx_ff) : gx_ff;
      gy_abs = gy_ff[39] ? (40'd0 - gy_ff) : gy_ff;
   end

   // Linear index and per-pixel step.
   always_comb begin
      step_pad_sum = {mxx_ff[39], mxx_ff} + 41'd128;
      step_rep_sum = {mxx_ff[39], mxx_ff} + 41'd1;
      step = pad ? step_pad_sum[39:8] : step_rep_sum[32:1];
      if (pad) begin
         if (pos_ff[31]) begin
            lin_idx = 9'd0;
         end else if (|pos_ff[31:16]) begin
            lin_idx = 9'd255;
         end else begin
            lin_idx = {1'b0, pos_ff[15:8]};
         end
      end else begin
         lin_idx = pos_ff[23:15] & mask9;
      end
   end

   // Span rounding, square-root saturation and radial index from the quotient.
   always_comb begin
      sx_pad = alu_xo[63:0] + 64'd256;
      sx_rep = alu_xo[63:0] + 64'd2;
      sx_rnd = w_ff + {{(AW-1){1'b0}}, 1'b1};
      sy_rnd = alu_xo + {{(AW-1){1'b0}}, 1'b1};
      s_val = (state_ff == gcg_pkg::ST_SQRT) ? alu_zo[39:0] : 40'hFF_FFFF_FFFF;
      a33 = alu_zo[32:0];
      a_scaled = wide ? ({a33, 9'b0} - {9'b0, a33}) : ({1'b0, a33, 8'b0} - {9'b0, a33});
      if (pad && (alu_zo == 64'd0)) begin
         rad_idx = 9'd0;
      end else if (pad && (|alu_zo[63:24])) begin
         rad_idx = mask9;
      end else begin
         rad_idx = a_scaled[32:24] & mask9;
      end
      span_cx = {req_tdata[52:41] & CMASK, 1'b1};
      span_cy = {req_tdata[64:53] & CMASK, 1'b1};
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      alu_cmd = '{start: 1'b0, op: gcg_pkg::ALU_MUL};
      alu_x = '0;
      alu_y = '0;
      alu_z = '0;
      pos_in = pos_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      w_in = w_ff;
      g_in = g_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         gcg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               unique case (gcg_pkg::req_kind_type'(req_tuser))
                  gcg_pkg::REQ_SPAN: begin
                     cx_in = span_cx;
                     cy_in = span_cy;
                     alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
                     alu_x = {{(AW-41){ox_ff[39]}}, ox_ff, 1'b0};
                     alu_y = gcg_pkg::sext40(mxx_ff);
                     alu_z = {51'b0, span_cx};
                     state_in = gcg_pkg::ST_SX_A;
                  end
                  gcg_pkg::REQ_PIXEL: begin
                     if (radial) begin
                        alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
                        alu_y = {{(AW-16){1'b0}}, f_abs};
                        alu_z = {48'b0, f_abs};
                        state_in = gcg_pkg::ST_F2;
                     end else begin
                        rd_en = 1'b1;
                        rd_addr = lin_idx;
                        pos_in = pos_ff + step;
                        state_in = gcg_pkg::ST_OUT;
                     end
                  end
                  gcg_pkg::REQ_LOAD, gcg_pkg::REQ_IGNORE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         gcg_pkg::ST_SX_A: begin
            if (alu_done) begin
               alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
               alu_x = alu_xo;
               alu_y = gcg_pkg::sext40(mxy_ff);
               alu_z = {51'b0, cy_ff};
               state_in = gcg_pkg::ST_SX_B;
            end
         end
         gcg_pkg::ST_SX_B: begin
            if (alu_done) begin
               if (radial) begin
                  w_in = alu_xo;
                  alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
                  alu_x = {{(AW-41){oy_ff[39]}}, oy_ff, 1'b0};
                  alu_y = gcg_pkg::sext40(myx_ff);
                  alu_z = {51'b0, cx_ff};
                  state_in = gcg_pkg::ST_SY_A;
               end else begin
                  pos_in = pad ? sx_pad[40:9] : sx_rep[33:2];
                  state_in = gcg_pkg::ST_IDLE;
               end
            end
         end
         gcg_pkg::ST_SY_A: begin
            if (alu_done) begin
               alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
               alu_x = alu_xo;
               alu_y = gcg_pkg::sext40(myy_ff);
               alu_z = {51'b0, cy_ff};
               state_in = gcg_pkg::ST_SY_B;
            end
         end
         gcg_pkg::ST_SY_B: begin
            if (alu_done) begin
               gx_in = sx_rnd[40:1] - {{15{f_val[16]}}, f_val, 8'b0};
               gy_in = sy_rnd[40:1];
               state_in = gcg_pkg::ST_IDLE;
            end
         end
         gcg_pkg::ST_F2: begin
            if (alu_done) begin
               g_in = 33'h1_0000_0000 - {1'b0, alu_xo[31:0]};
               alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
               alu_y = {{(AW-40){1'b0}}, gy_abs};
               alu_z = {24'b0, gy_abs};
               state_in = gcg_pkg::ST_Y2;
            end
         end
         gcg_pkg::ST_Y2: begin
            if (alu_done) begin
               w_in = alu_xo;
               alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
               alu_y = {{(AW-40){1'b0}}, gx_abs};
               alu_z = {24'b0, gx_abs};
               state_in = gcg_pkg::ST_X2;
            end
         end
         gcg_pkg::ST_X2: begin
            // Seeding with x*x scaled up by 2^32 folds the later add into the product.
            if (alu_done) begin
               alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
               alu_x = {alu_xo[AW-33:0], 32'b0};
               alu_y = w_ff;
               alu_z = {31'b0, g_ff};
               state_in = gcg_pkg::ST_D;
            end
         end
         gcg_pkg::ST_D: begin
            if (alu_done) begin
               if (|alu_xo[AW-1:112]) begin
                  // The root would not fit in 40 bits, so it saturates.
                  alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
                  alu_x = {72'b0, s_val, 16'b0};
                  alu_y = f_neg ? (AW'(0) - gcg_pkg::sext40(gx_ff)) : gcg_pkg::sext40(gx_ff);
                  alu_z = {48'b0, f_abs};
                  state_in = gcg_pkg::ST_NUM;
               end else begin
                  alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_SQRT};
                  alu_y = {48'b0, alu_xo[111:32]};
                  state_in = gcg_pkg::ST_SQRT;
               end
            end
         end
         gcg_pkg::ST_SQRT: begin
            if (alu_done) begin
               alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_MUL};
               alu_x = {72'b0, s_val, 16'b0};
               alu_y = f_neg ? (AW'(0) - gcg_pkg::sext40(gx_ff)) : gcg_pkg::sext40(gx_ff);
               alu_z = {48'b0, f_abs};
               state_in = gcg_pkg::ST_NUM;
            end
         end
         gcg_pkg::ST_NUM: begin
            if (alu_done) begin
               alu_cmd = '{start: 1'b1, op: gcg_pkg::ALU_DIV};
               alu_y = alu_xo[AW-1] ? '0 : {49'b0, alu_xo[62:0], 16'b0};
               state_in = gcg_pkg::ST_DIV;
            end
         end
         gcg_pkg::ST_DIV: begin
            if (alu_done) begin
               rd_en = 1'b1;
               rd_addr = rad_idx;
               gx_in = gx_ff + mxx_ff;
               gy_in = gy_ff + myx_ff;
               state_in = gcg_pkg::ST_OUT;
            end
         end
         gcg_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = rd_data;
               state_in = gcg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gcg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff <= 32'd0;
         gx_ff <= 40'd0;
         gy_ff <= 40'd0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff <= pos_in;
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      w_ff <= w_in;
      g_ff <= g_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 3'd0;
         focal_ff <= 17'd0;
         mxx_ff <= 40'd16777216;
         mxy_ff <= 40'd0;
         myx_ff <= 40'd0;
         myy_ff <= 40'd16777216;
         ox_ff <= 40'd0;
         oy_ff <= 40'd0;
      end else if (csr_valid) begin
         unique case (gcg_pkg::csr_reg_type'(csr_index))
            gcg_pkg::CSR_FILL_MODE:   mode_ff <= csr_data[2:0];
            gcg_pkg::CSR_FOCAL_RATIO: focal_ff <= csr_data[16:0];
            gcg_pkg::CSR_MATRIX_XX:   mxx_ff <= csr_data;
            gcg_pkg::CSR_MATRIX_XY:   mxy_ff <= csr_data;
            gcg_pkg::CSR_MATRIX_YX:   myx_ff <= csr_data;
            gcg_pkg::CSR_MATRIX_YY:   myy_ff <= csr_data;
            gcg_pkg::CSR_OFFSET_X:    ox_ff <= csr_data;
            gcg_pkg::CSR_OFFSET_Y:    oy_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign wr_en = req_tvalid && req_tready && (req_tuser == gcg_pkg::REQ_LOAD);

   gcg_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .cmd     (alu_cmd),
      .x_init  (alu_x),
      .y_init  (alu_y),
      .z_init  (alu_z),
      .divisor (g_ff),
      .done    (alu_done),
      .x_out   (alu_xo),
      .z_out   (alu_zo)
   );

   gcg_ramp u_ramp (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_tdata[8:0]),
      .wr_data (req_tdata[40:9]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == gcg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff != gcg_pkg::ST_IDLE) && (state_ff != gcg_pkg::ST_OUT))
      else $error("arithmetic unit finished with no operation outstanding");

   a_linear_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == gcg_pkg::REQ_PIXEL) && !radial)
      |=> state_ff == gcg_pkg::ST_OUT)
      else $error("linear pixel did not go straight to the result stage");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == gcg_pkg::ST_OUT)
      else $error("result beat raised outside the result stage");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench of the gradient colour generator, with its own colour predictor.
`timescale 1ns / 100ps
module testbench;

   localparam logic [2:0] MODE_LIN_PAD = 3'd0;
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 110;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [39:0] csr_data = '0;

   // Predictor copy of the registers and the running state.
   logic [2:0] cfg_mode = MODE_LIN_PAD;
   logic [16:0] cfg_focal = '0;
   logic signed [39:0] cfg_xx = 40'sd16777216, cfg_xy = '0, cfg_yx = '0;
   logic signed [39:0] cfg_yy = 40'sd16777216, cfg_ox = '0, cfg_oy = '0;
   logic [31:0] ramp [gcg_pkg::TABLE_DEPTH];
   logic [31:0] lin_pos = '0;
   logic signed [39:0] rad_gx = '0, rad_gy = '0;

   logic [31:0] colour_expect_q[$];
   int error_count = 0;
   int cycle_count = 0;
   bit calm = 1'b0;
   int hold = 0;

   gradient_colour_generator_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [63:0] focal_clamped();
      logic signed [63:0] f;
      f = $signed(cfg_focal);
      if (f > gcg_pkg::FOCAL_LIMIT) f = gcg_pkg::FOCAL_LIMIT;
      if (f < -gcg_pkg::FOCAL_LIMIT) f = -gcg_pkg::FOCAL_LIMIT;
      return f;
   endfunction

   // Solves the focal quadratic exactly and scales the root to a ramp index.
   function automatic logic [8:0] radial_entry(logic [8:0] mask, bit pad);
      logic signed [63:0] gx, gy, f, n;
      logic [63:0] ff;
      logic [127:0] ax, ay, g, d, s, cand, num, a;
      gx = rad_gx;
      gy = rad_gy;
      f = focal_clamped();
      ff = f * f;
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      g = (128'd1 << 32) - {64'd0, ff};
      d = ax * ax + (((ay * ay) * g) >> 32);
      s = '0;
      for (int b = 39; b >= 0; b--) begin
         cand = s | (128'd1 << b);
         if (cand * cand <= d) s = cand;
      end
      n = gx * f + $signed(s[63:0] << 16);
      if (n < 0) n = 0;
      num = {64'd0, n} << 16;
      a = num / g;
      if (pad) begin
         if (a == 0) return '0;
         if (a >= (128'd1 << 24)) return mask;
         return 9'((a * mask) >> 24);
      end
      return 9'((a * mask) >> 24) & mask;
   endfunction

   task automatic predict_item(gcg_pkg::req_kind_type kind, logic [8:0] idx,
                               logic [31:0] colour, logic [11:0] x, logic [11:0] y);
      bit radial, pad;
      logic [8:0] mask, entry;
      logic signed [63:0] m00, cx, cy, sx, sy, p, step;
      radial = cfg_mode inside {gcg_pkg::MODE_RAD_PAD, gcg_pkg::MODE_RAD_REPEAT,
                                gcg_pkg::MODE_RAD_REFLECT};
      pad = !(cfg_mode inside {gcg_pkg::MODE_LIN_REPEAT, gcg_pkg::MODE_LIN_REFLECT,
                               gcg_pkg::MODE_RAD_REPEAT, gcg_pkg::MODE_RAD_REFLECT});
      mask = (cfg_mode == gcg_pkg::MODE_LIN_REFLECT || cfg_mode == gcg_pkg::MODE_RAD_REFLECT)
             ? 9'd511 : 9'd255;
      m00 = cfg_xx;
      case (kind)
         gcg_pkg::REQ_LOAD: ramp[idx] = colour;
         gcg_pkg::REQ_SPAN: begin
            cx = $signed({51'd0, x, 1'b1});
            cy = $signed({51'd0, y, 1'b1});
            sx = m00 * cx + 64'(cfg_xy) * cy + 2 * 64'(cfg_ox);
            sy = 64'(cfg_yx) * cx + 64'(cfg_yy) * cy + 2 * 64'(cfg_oy);
            if (radial) begin
               rad_gx = 40'(((sx + 1) >>> 1) - focal_clamped() * 256);
               rad_gy = 40'((sy + 1) >>> 1);
            end else if (pad) begin
               lin_pos = 32'((sx + 256) >>> 9);
            end else begin
               lin_pos = 32'((sx + 2) >>> 2);
            end
         end
         gcg_pkg::REQ_PIXEL: begin
            if (radial) begin
               entry = radial_entry(mask, pad);
               rad_gx = rad_gx + cfg_xx;
               rad_gy = rad_gy + cfg_yx;
            end else if (pad) begin
               p = $signed(lin_pos);
               if (p < 0) entry = 9'd0;
               else if ((p >>> 8) > 255) entry = 9'd255;
               else entry = 9'(p >>> 8);
               step = (m00 + 128) >>> 8;
               lin_pos = lin_pos + step[31:0];
            end else begin
               entry = 9'(lin_pos >> 15) & mask;
               step = (m00 + 1) >>> 1;
               lin_pos = lin_pos + step[31:0];
            end
            colour_expect_q.push_back(ramp[entry]);
         end
         default: ;
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives one item and holds it until its beat is taken; valid stays high
   // when the next item is to follow at once.
   task automatic send_item(gcg_pkg::req_kind_type kind, logic [8:0] idx = '0,
                            logic [31:0] colour = '0,
                            logic [11:0] x = '0, logic [11:0] y = '0);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, y, x, colour, idx};
      do @(posedge clock); while (!req_tready);
      predict_item(kind, idx, colour, x, y);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (colour_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(gcg_pkg::csr_reg_type r, logic [39:0] v);
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      case (r)
         gcg_pkg::CSR_FILL_MODE:   cfg_mode = v[2:0];
         gcg_pkg::CSR_FOCAL_RATIO: cfg_focal = v[16:0];
         gcg_pkg::CSR_MATRIX_XX:   cfg_xx = v;
         gcg_pkg::CSR_MATRIX_XY:   cfg_xy = v;
         gcg_pkg::CSR_MATRIX_YX:   cfg_yx = v;
         gcg_pkg::CSR_MATRIX_YY:   cfg_yy = v;
         gcg_pkg::CSR_OFFSET_X:    cfg_ox = v;
         default:                  cfg_oy = v;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [2:0] mode, logic [16:0] focal, logic [39:0] xx,
                             logic [39:0] xy, logic [39:0] yx, logic [39:0] yy,
                             logic [39:0] ox, logic [39:0] oy);
      wait_idle();
      csr_write(gcg_pkg::CSR_FILL_MODE, {37'd0, mode});
      csr_write(gcg_pkg::CSR_FOCAL_RATIO, {23'd0, focal});
      csr_write(gcg_pkg::CSR_MATRIX_XX, xx);
      csr_write(gcg_pkg::CSR_MATRIX_XY, xy);
      csr_write(gcg_pkg::CSR_MATRIX_YX, yx);
      csr_write(gcg_pkg::CSR_MATRIX_YY, yy);
      csr_write(gcg_pkg::CSR_OFFSET_X, ox);
      csr_write(gcg_pkg::CSR_OFFSET_Y, oy);
   endtask

   task automatic run_span(logic [11:0] x, logic [11:0] y, int pixels);
      send_item(gcg_pkg::REQ_SPAN, '0, '0, x, y);
      repeat (pixels) send_item(gcg_pkg::REQ_PIXEL);
   endtask

   function automatic logic [39:0] moderate_coeff();
      return 40'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
   endfunction

   function automatic logic [39:0] wide_random();
      return {$urandom, $urandom} & 40'hFF_FFFF_FFFF;
   endfunction

   // Every ramp entry is loaded before any pixel can read it.
   task automatic test_ramp_load();
      for (int i = 0; i < gcg_pkg::TABLE_DEPTH; i++)
         send_item(gcg_pkg::REQ_LOAD, 9'(i),
                   (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
   endtask

   task automatic test_reset_state();
      run_span(12'd0, 12'd0, 3);
      send_item(gcg_pkg::REQ_IGNORE, 9'h1FF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
      send_item(gcg_pkg::REQ_PIXEL);
   endtask

   task automatic test_linear_modes();
      logic [2:0] modes [5] = '{MODE_LIN_PAD, gcg_pkg::MODE_LIN_REPEAT,
                                gcg_pkg::MODE_LIN_REFLECT, MODE_SPARE_LO, MODE_SPARE_HI};
      foreach (modes[i]) begin
         set_config(modes[i], '0, 40'd98304, 40'd4096, -40'sd2048, 40'd65536,
                    -40'sd8388608, 40'd1048576);
         run_span(12'd4095, 12'd0, 2);
         run_span(12'd0, 12'd4095, 2);
      end
      // Extreme coefficients make the accumulators wrap.
      set_config(gcg_pkg::MODE_LIN_REPEAT, '0, 40'h7F_FFFF_FFFF, 40'h80_0000_0000,
                 40'h7F_FFFF_FFFF, 40'h80_0000_0000, 40'h80_0000_0000, 40'h7F_FFFF_FFFF);
      run_span(12'd4095, 12'd4095, 3);
   endtask

   task automatic test_radial_modes();
      logic [16:0] focals [4] = '{17'd64880, -17'sd64880, 17'h0FFFF, 17'h10000};
      foreach (focals[i]) begin
         set_config(gcg_pkg::MODE_RAD_PAD + 3'(i % 3), focals[i], 40'd131072, 40'd0, 40'd0,
                    40'd131072, -40'sd16777216, -40'sd8388608);
         run_span(12'd0, 12'd0, 2);
         run_span(12'd255, 12'd4095, 1);
      end
      set_config(gcg_pkg::MODE_RAD_REFLECT, 17'd0, 40'h80_0000_0000, 40'h7F_FFFF_FFFF,
                 40'h7F_FFFF_FFFF, 40'h80_0000_0000, 40'h7F_FFFF_FFFF, 40'h80_0000_0000);
      run_span(12'd4095, 12'd4095, 2);
   endtask

   task automatic test_random_spans();
      int done, r;
      logic [39:0] c [6];
      done = 0;
      while (done < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 9);
         foreach (c[i])
            c[i] = (r == 0) ? wide_random()
                 : (i >= 4) ? 40'($signed($urandom_range(0, 1 << 27)) - (1 << 26))
                 : moderate_coeff();
         set_config(3'($urandom_range(0, 7)), 17'($urandom), c[0], c[1], c[2], c[3],
                    c[4], c[5]);
         repeat ($urandom_range(2, 5)) begin
            send_item(gcg_pkg::REQ_SPAN, '0, '0, 12'($urandom), 12'($urandom));
            done++;
            repeat ($urandom_range(1, 10)) begin
               r = $urandom_range(0, 99);
               if (r < 4) send_item(gcg_pkg::REQ_LOAD, 9'($urandom), $urandom);
               else if (r < 7) send_item(gcg_pkg::REQ_IGNORE, 9'($urandom), $urandom,
                                         12'($urandom), 12'($urandom));
               else send_item(gcg_pkg::REQ_PIXEL, 9'($urandom), $urandom,
                              12'($urandom), 12'($urandom));
               if (r >= 4 && r < 7) continue;
               done++;
            end
         end
      end
      calm = 1'b0;
   endtask

   // Receiver side: runs of stalls, mostly short and now and then long.
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
         hold <= 0;
      end else if (hold > 0) begin
         rsp_tready <= 1'b0;
         hold <= hold - 1;
      end else if ($urandom_range(0, 99) < 30) begin
         rsp_tready <= 1'b0;
         hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (colour_expect_q.size() == 0) begin
            $error("pixel_colour: no result expected, got %h", rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tdata !== colour_expect_q[0]) begin
               $error("pixel_colour: expected %h, got %h", colour_expect_q[0], rsp_tdata);
               error_count++;
            end
            void'(colour_expect_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ramp_load();
      test_reset_state();
      test_linear_modes();
      test_radial_modes();
      test_random_spans();
      wait_idle();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/gcg_pkg.sv
hw/rtl/gcg_alu.sv
hw/rtl/gcg_ramp.sv
hw/rtl/gradient_colour_generator_unit.sv
test/testbench.sv
